FILE: rtl/core/assert_macros.svh
// Assertion helpers for the lcdser checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define LCDSER_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define LCDSER_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/lcdser_pkg.sv
`default_nettype none

package lcdser_pkg;

   typedef enum logic [1:0] {
      OP_CHAR   = 2'd0,
      OP_CURSOR = 2'd1,
      OP_CMD    = 2'd2,
      OP_DATA   = 2'd3
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] payload_byte;
      logic [2:0] text_row;
      logic [3:0] text_column;
   } req_payload_type;

   typedef struct packed {
      logic serial_bit;
      logic data_not_command;
      logic byte_end;
      logic last;
   } rsp_payload_type;

   localparam int SEQ_W   = 48;
   localparam int COUNT_W = 6;

   localparam logic [COUNT_W-1:0] BITS_CHAR   = 6'd48;
   localparam logic [COUNT_W-1:0] BITS_CURSOR = 6'd16;
   localparam logic [COUNT_W-1:0] BITS_RAW    = 6'd8;
   localparam logic [COUNT_W-1:0] BITS_NONE   = 6'd0;
   localparam logic [COUNT_W-1:0] BITS_ONE    = 6'd1;

   localparam logic [7:0] FONT_FIRST = 8'h20;
   localparam logic [7:0] FONT_LAST  = 8'h7B;
   localparam logic [7:0] FONT_SUBST = 8'h5C;
   localparam int         FONT_SIZE  = 92;

   localparam logic [7:0] CMD_SET_Y = 8'h40;
   localparam logic [7:0] CMD_SET_X = 8'h80;

   localparam logic [2:0] ROW_MAX = 3'd6;
   localparam logic [3:0] COL_MAX = 4'd14;

   // five columns per glyph, first column in the top byte
   localparam logic [39:0] FONT_GLYPHS [0:FONT_SIZE-1] = '{
      40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14,
      40'h242a7f2a12, 40'hc4c8102646, 40'h3649552250, 40'h0005030000,
      40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
      40'h0000503000, 40'h1010101010, 40'h0060600000, 40'h2010080402,
      40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
      40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
      40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h324959513e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
      40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
      40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
      40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
      40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
      40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
      40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
      40'h552a552a55, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
      40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
      40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
      40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
      40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
      40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
      40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h00083e4100
   };

endpackage

`default_nettype wire

FILE: rtl/core/lcdser_stream_if.sv
`default_nettype none

interface lcdser_req_if;
   import lcdser_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface lcdser_rsp_if;
   import lcdser_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/text_to_lcd_serial_stream_top.sv
`default_nettype none

// Text to LCD serial stream. Each request is turned into a byte sequence at
// transfer time (font lookup for characters, Y/X commands for the cursor, or
// the raw byte) and shifted out MSB first, one bit per response transfer:
// six bytes for a character, two for a valid cursor, one for a raw byte. An
// out-of-range cursor is taken and produces nothing. The output shift
// register sets the pace; the next request is taken in the cycle its
// predecessor's last bit moves into the response register, so back-to-back
// requests keep the serial line busy without gaps.
module text_to_lcd_serial_stream_top (
   input wire           clock,
   input wire           reset,
   lcdser_req_if.sink   req_channel,
   lcdser_rsp_if.source rsp_channel
);
   import lcdser_pkg::*;

   logic [SEQ_W-1:0]   seq_ff, seq_in, seq_load;
   logic [COUNT_W-1:0] cnt_ff, cnt_in, cnt_load;
   logic               dnc_ff, dnc_in, dnc_load;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_ff, rsp_in;

   logic       emit;
   logic       req_ready;
   logic       req_transfer;
   logic [7:0] code;
   logic [6:0] glyph_idx;
   logic [39:0] glyph;
   logic [2:0] row_m1;
   logic [3:0] col_m1;
   logic [6:0] x_addr;
   logic       cursor_ok;

   always_comb begin
      req_payload_type r;
      r         = req_channel.payload;
      code      = (r.payload_byte < FONT_FIRST || r.payload_byte > FONT_LAST) ?
                  FONT_SUBST : r.payload_byte;
      glyph_idx = 7'(code - FONT_FIRST);
      glyph     = FONT_GLYPHS[glyph_idx];
      row_m1    = 3'(r.text_row - 3'd1);
      col_m1    = 4'(r.text_column - 4'd1);
      x_addr    = 7'({1'b0, col_m1, 2'b00}) + 7'({2'b00, col_m1, 1'b0});
      cursor_ok = (r.text_row != 3'd0) && (r.text_row <= ROW_MAX) &&
                  (r.text_column != 4'd0) && (r.text_column <= COL_MAX);
      seq_load  = '0;
      cnt_load  = BITS_NONE;
      dnc_load  = 1'b0;
      unique case (r.op)
         OP_CHAR: begin
            seq_load = {glyph[38:32], 1'b0, glyph[30:24], 1'b0, glyph[22:16], 1'b0,
                        glyph[14:8], 1'b0, glyph[6:0], 1'b0, 8'h00};
            cnt_load = BITS_CHAR;
            dnc_load = 1'b1;
         end
         OP_CURSOR: begin
            seq_load = {CMD_SET_Y | {5'b00000, row_m1}, CMD_SET_X | {1'b0, x_addr},
                        32'h0};
            cnt_load = cursor_ok ? BITS_CURSOR : BITS_NONE;
            dnc_load = 1'b0;
         end
         OP_CMD: begin
            seq_load = {r.payload_byte, 40'h0};
            cnt_load = BITS_RAW;
            dnc_load = 1'b0;
         end
         OP_DATA: begin
            seq_load = {r.payload_byte, 40'h0};
            cnt_load = BITS_RAW;
            dnc_load = 1'b1;
         end
         default: begin
            seq_load = '0;
            cnt_load = BITS_NONE;
            dnc_load = 1'b0;
         end
      endcase
   end

   assign emit         = (cnt_ff != BITS_NONE) && (!rsp_valid_ff || rsp_channel.ready);
   assign req_ready    = (cnt_ff == BITS_NONE) || ((cnt_ff == BITS_ONE) && emit);
   assign req_transfer = req_channel.valid && req_ready;

   always_comb begin
      if (req_transfer) begin
         seq_in = seq_load;
         cnt_in = cnt_load;
         dnc_in = dnc_load;
      end else if (emit) begin
         seq_in = {seq_ff[SEQ_W-2:0], 1'b0};
         cnt_in = cnt_ff - BITS_ONE;
         dnc_in = dnc_ff;
      end else begin
         seq_in = seq_ff;
         cnt_in = cnt_ff;
         dnc_in = dnc_ff;
      end

      if (emit) begin
         rsp_valid_in           = 1'b1;
         rsp_in.serial_bit       = seq_ff[SEQ_W-1];
         rsp_in.data_not_command = dnc_ff;
         rsp_in.byte_end         = (cnt_ff[2:0] == 3'd1);
         rsp_in.last             = (cnt_ff == BITS_ONE);
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_channel.ready;
         rsp_in       = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= BITS_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff <= seq_in;
      dnc_ff <= dnc_in;
      rsp_ff <= rsp_in;
   end

   assign req_channel.ready   = req_ready;
   assign rsp_channel.valid   = rsp_valid_ff;
   assign rsp_channel.payload = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/core/lcdser_checker.sv
`default_nettype none

`include "assert_macros.svh"

module lcdser_checker (
   input wire                        clock,
   input wire                        reset,
   input wire                        req_ready,
   input wire                        rsp_valid,
   input wire                        rsp_ready,
   input lcdser_pkg::rsp_payload_type rsp_payload
);
   import lcdser_pkg::*;

   `LCDSER_ASSERT(rsp_hold_valid, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp valid dropped under stall")
   `LCDSER_ASSERT(rsp_hold_data, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_payload), "rsp payload changed under stall")
   `LCDSER_ASSERT(req_blocked_mid_item, clock, reset, rsp_valid && !rsp_ready && !rsp_payload.last |-> !req_ready, "request taken while an item is still streaming")
   `LCDSER_ASSERT(last_ends_byte, clock, reset, rsp_valid && rsp_payload.last |-> rsp_payload.byte_end, "item ended inside a byte")
   `LCDSER_ASSERT_ALWAYS(rsp_idle_after_reset, clock, reset |=> !rsp_valid, "rsp valid right after reset")

endmodule

bind text_to_lcd_serial_stream_top lcdser_checker u_lcdser_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_channel.ready),
   .rsp_valid   (rsp_channel.valid),
   .rsp_ready   (rsp_channel.ready),
   .rsp_payload (rsp_channel.payload)
);

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import lcdser_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int TAIL_CYCLES = 60;
   localparam int MAX_REPORTS = 40;

   localparam logic [7:0] GLYPH_LO    = 8'h20;
   localparam logic [7:0] GLYPH_HI    = 8'h7B;
   localparam logic [7:0] GLYPH_CHECK = 8'h5C;

   localparam logic [39:0] GLYPH_ROM [0:91] = '{
      40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14,
      40'h242a7f2a12, 40'hc4c8102646, 40'h3649552250, 40'h0005030000,
      40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
      40'h0000503000, 40'h1010101010, 40'h0060600000, 40'h2010080402,
      40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
      40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
      40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h324959513e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
      40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
      40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
      40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
      40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
      40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
      40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
      40'h552a552a55, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
      40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
      40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
      40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
      40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
      40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
      40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h00083e4100
   };

   logic clock;
   logic reset;

   lcdser_req_if req_if ();
   lcdser_rsp_if rsp_if ();

   text_to_lcd_serial_stream_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_if),
      .rsp_channel (rsp_if)
   );

   req_payload_type request_queue[$];
   rsp_payload_type serial_bits_due[$];
   int              mismatches;
   int              stall_cycles;
   bit              no_idle;

   // expected serial stream of one byte, MSB first
   function automatic void queue_byte(logic [7:0] value, logic dnc);
      rsp_payload_type bit_item;
      for (int b = 7; b >= 0; b--) begin
         bit_item.serial_bit       = value[b];
         bit_item.data_not_command = dnc;
         bit_item.byte_end         = (b == 0);
         bit_item.last             = 1'b0;
         serial_bits_due.push_back(bit_item);
      end
   endfunction

   function automatic void expand_request(req_payload_type r);
      int         start;
      logic [7:0] code;
      logic [39:0] glyph;
      logic [7:0] column_bits;
      start = serial_bits_due.size();
      case (r.op)
         OP_CHAR: begin
            code = r.payload_byte;
            if (code < GLYPH_LO || code > GLYPH_HI) begin
               code = GLYPH_CHECK;
            end
            glyph = GLYPH_ROM[code - GLYPH_LO];
            for (int i = 0; i < 5; i++) begin
               column_bits = glyph[39 - 8 * i -: 8];
               queue_byte({column_bits[6:0], 1'b0}, 1'b1);
            end
            queue_byte(8'h00, 1'b1);
         end
         OP_CURSOR: begin
            if (r.text_row >= 3'd1 && r.text_row <= 3'd6 &&
                r.text_column >= 4'd1 && r.text_column <= 4'd14) begin
               queue_byte(8'h40 | {5'd0, r.text_row - 3'd1}, 1'b0);
               queue_byte(8'h80 | ((8'(r.text_column) - 8'd1) * 8'd6 & 8'h7F), 1'b0);
            end
         end
         OP_CMD: begin
            queue_byte(r.payload_byte, 1'b0);
         end
         default: begin
            queue_byte(r.payload_byte, 1'b1);
         end
      endcase
      if (serial_bits_due.size() > start) begin
         serial_bits_due[serial_bits_due.size() - 1].last = 1'b1;
      end
   endfunction

   function automatic req_payload_type make_request(op_type op, logic [7:0] value,
                                                    logic [2:0] row, logic [3:0] col);
      req_payload_type r;
      r.op           = op;
      r.payload_byte = value;
      r.text_row     = row;
      r.text_column  = col;
      return r;
   endfunction

   function automatic req_payload_type random_request();
      req_payload_type r;
      r = make_request(op_type'($urandom_range(3)), 8'($urandom_range(255)),
                       3'($urandom_range(7)), 4'($urandom_range(15)));
      if (r.op == OP_CHAR && $urandom_range(99) < 80) begin
         r.payload_byte = 8'($urandom_range(GLYPH_HI, GLYPH_LO));
      end
      if (r.op == OP_CURSOR && $urandom_range(99) < 75) begin
         r.text_row    = 3'($urandom_range(6, 1));
         r.text_column = 4'($urandom_range(14, 1));
      end
      return r;
   endfunction

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (request_queue.size() != 0 || req_if.valid || serial_bits_due.size() != 0);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.payload <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expand_request(req_if.payload);
         end
         if (!req_if.valid || req_if.ready) begin
            if (request_queue.size() != 0 && (no_idle || $urandom_range(99) >= 35)) begin
               req_if.payload <= request_queue.pop_front();
               req_if.valid   <= 1'b1;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // serial stream monitor
   always @(posedge clock) begin
      rsp_payload_type due;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (serial_bits_due.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("%0t: unexpected transfer, expected none, actual %b", $realtime,
                           rsp_if.payload);
               end
            end else begin
               due = serial_bits_due.pop_front();
               if (rsp_if.payload.serial_bit !== due.serial_bit ||
                   rsp_if.payload.data_not_command !== due.data_not_command ||
                   rsp_if.payload.byte_end !== due.byte_end ||
                   rsp_if.payload.last !== due.last) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("%0t: bit/dnc/end/last expected %b actual %b", $realtime,
                              due, rsp_if.payload);
                  end
               end
            end
         end
         rsp_if.ready <= no_idle || $urandom_range(99) >= 35;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      no_idle        = 1'b0;
      reset          = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // font edges, substitution, cursor limits, raw bytes
      request_queue.push_back(make_request(OP_CHAR, 8'h20, 3'd7, 4'd15));
      request_queue.push_back(make_request(OP_CHAR, 8'h7B, 3'd0, 4'd0));
      request_queue.push_back(make_request(OP_CHAR, 8'h1F, 3'd2, 4'd3));
      request_queue.push_back(make_request(OP_CHAR, 8'h7C, 3'd5, 4'd9));
      request_queue.push_back(make_request(OP_CHAR, 8'h00, 3'd0, 4'd0));
      request_queue.push_back(make_request(OP_CHAR, 8'hFF, 3'd7, 4'd15));
      request_queue.push_back(make_request(OP_CHAR, 8'h41, 3'd1, 4'd1));
      request_queue.push_back(make_request(OP_CHAR, 8'h5C, 3'd3, 4'd4));
      request_queue.push_back(make_request(OP_CHAR, 8'h25, 3'd3, 4'd4));
      request_queue.push_back(make_request(OP_CURSOR, 8'h00, 3'd1, 4'd1));
      request_queue.push_back(make_request(OP_CURSOR, 8'hFF, 3'd6, 4'd14));
      request_queue.push_back(make_request(OP_CURSOR, 8'h55, 3'd0, 4'd5));
      request_queue.push_back(make_request(OP_CURSOR, 8'hAA, 3'd7, 4'd3));
      request_queue.push_back(make_request(OP_CURSOR, 8'h12, 3'd3, 4'd0));
      request_queue.push_back(make_request(OP_CURSOR, 8'h34, 3'd3, 4'd15));
      request_queue.push_back(make_request(OP_CURSOR, 8'h80, 3'd2, 4'd7));
      request_queue.push_back(make_request(OP_CMD, 8'h00, 3'd7, 4'd15));
      request_queue.push_back(make_request(OP_CMD, 8'hFF, 3'd0, 4'd0));
      request_queue.push_back(make_request(OP_CMD, 8'hA5, 3'd4, 4'd8));
      request_queue.push_back(make_request(OP_DATA, 8'h00, 3'd0, 4'd0));
      request_queue.push_back(make_request(OP_DATA, 8'hFF, 3'd7, 4'd15));
      request_queue.push_back(make_request(OP_DATA, 8'h5A, 3'd6, 4'd14));
      wait_drained();

      for (int i = 0; i < 35; i++) begin
         request_queue.push_back(random_request());
      end
      wait_drained();

      // back-to-back transfers on both sides
      no_idle = 1'b1;
      for (int i = 0; i < 35; i++) begin
         request_queue.push_back(random_request());
      end
      wait_drained();
      no_idle = 1'b0;

      for (int i = 0; i < 8; i++) begin
         request_queue.push_back(random_request());
      end
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && serial_bits_due.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/lcdser_pkg.sv
rtl/core/lcdser_stream_if.sv
rtl/core/text_to_lcd_serial_stream_top.sv
rtl/core/lcdser_checker.sv
dv/tb.sv
